// ----- rtl/core/bapc_pkg.sv -----
// Package with the shared types, codes and defaults of the button classifier.
package bapc_pkg;

  // Default width of the held-time counters and timers.
  localparam int TIMER_WIDTH_DEF = 16;

  // Field widths of the channels.
  localparam int ROT_W      = 16;
  localparam int OFFSET_W   = 8;
  localparam int BTN_W      = 3;
  localparam int HANDLER_W  = 3;
  localparam int MAP_W      = 24;
  localparam int DELAY_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register reset values.
  localparam logic [MAP_W-1:0]   BUTTON_MAP_RST  = 24'hFAC688;
  localparam logic [DELAY_W-1:0] SLOW_DELAY_RST  = 16'd400;
  localparam logic [DELAY_W-1:0] FAST_DELAY_RST  = 16'd50;
  localparam logic [DELAY_W-1:0] SHORT_LIMIT_RST = 16'd500;
  localparam logic [DELAY_W-1:0] LONG_LIMIT_RST  = 16'd2000;

  // Number of repeats after which the fast delay applies.
  localparam logic [1:0] REPEATS_FAST = 2'd3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUTTON_MAP  = 3'd0,
    REG_SLOW_DELAY  = 3'd1,
    REG_FAST_DELAY  = 3'd2,
    REG_SHORT_LIMIT = 3'd3,
    REG_LONG_LIMIT  = 3'd4
  } reg_idx_t;

  // Input action codes.
  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_EDGE   = 2'd1,
    ACT_ROTATE = 2'd2
  } action_t;

  // Handler codes of the button map.
  typedef enum logic [HANDLER_W-1:0] {
    HND_CONFIRM = 3'd0,
    HND_BACK    = 3'd1,
    HND_UP      = 3'd2,
    HND_DOWN    = 3'd3,
    HND_BLINK_L = 3'd4,
    HND_BLINK_R = 3'd5
  } handler_t;

  // Classified operation handed from the front end to the back end.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TICK,
    OP_ROTATE,
    OP_CONFIRM,
    OP_BACK,
    OP_UP,
    OP_DOWN,
    OP_BLINK_L,
    OP_BLINK_R
  } op_t;

  typedef enum logic [1:0] {
    CEV_NONE  = 2'd0,
    CEV_SHORT = 2'd1,
    CEV_LONG  = 2'd2,
    CEV_VLONG = 2'd3
  } confirm_ev_t;

  typedef enum logic [1:0] {
    BEV_NONE  = 2'd0,
    BEV_SHORT = 2'd1,
    BEV_LONG  = 2'd2
  } back_ev_t;

  typedef enum logic [1:0] {
    BLINK_OFF   = 2'd0,
    BLINK_LEFT  = 2'd1,
    BLINK_RIGHT = 2'd2,
    BLINK_BOTH  = 2'd3
  } blink_t;

  // One queued operation.
  typedef struct packed {
    op_t                  op;
    logic                 pressed;
    logic [OFFSET_W-1:0]  offset;
  } op_item_t;

  // Current configuration register contents.
  typedef struct packed {
    logic [MAP_W-1:0]   button_map;
    logic [DELAY_W-1:0] slow_delay;
    logic [DELAY_W-1:0] fast_delay;
    logic [DELAY_W-1:0] short_limit;
    logic [DELAY_W-1:0] long_limit;
  } cfg_t;

endpackage

// ----- rtl/core/bapc_channels.sv -----
// Channel interfaces of the button classifier: input, result and configuration.
interface bapc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           action;
  logic [bapc_pkg::BTN_W-1:0]           button_index;
  logic                                 pressed;
  logic signed [bapc_pkg::OFFSET_W-1:0] rotate_offset;

  modport source (output valid, action, button_index, pressed, rotate_offset, input ready);
  modport sink   (input valid, action, button_index, pressed, rotate_offset, output ready);
endinterface

interface bapc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bapc_pkg::ROT_W-1:0] rotation_count;
  logic [1:0]                        confirm_event;
  logic [1:0]                        back_event;
  logic [1:0]                        blink_mode;

  modport source (output valid, rotation_count, confirm_event, back_event, blink_mode,
                  input ready);
  modport sink   (input valid, rotation_count, confirm_event, back_event, blink_mode,
                  output ready);
endinterface

interface bapc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bapc_pkg::CFG_IDX_W-1:0]     reg_index;
  logic [bapc_pkg::CFG_DATA_W-1:0]    wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- rtl/core/bapc_cfg_regs.sv -----
// Configuration register file of the button classifier.
module bapc_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  bapc_cfg_if.sink      cfg_ch,
  output bapc_pkg::cfg_t cfg
);
  import bapc_pkg::*;

  cfg_t cfg_r;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  // Register write on each configuration beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.button_map  <= BUTTON_MAP_RST;
      cfg_r.slow_delay  <= SLOW_DELAY_RST;
      cfg_r.fast_delay  <= FAST_DELAY_RST;
      cfg_r.short_limit <= SHORT_LIMIT_RST;
      cfg_r.long_limit  <= LONG_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.reg_index))
        REG_BUTTON_MAP:  cfg_r.button_map  <= cfg_ch.wdata[MAP_W-1:0];
        REG_SLOW_DELAY:  cfg_r.slow_delay  <= cfg_ch.wdata[DELAY_W-1:0];
        REG_FAST_DELAY:  cfg_r.fast_delay  <= cfg_ch.wdata[DELAY_W-1:0];
        REG_SHORT_LIMIT: cfg_r.short_limit <= cfg_ch.wdata[DELAY_W-1:0];
        REG_LONG_LIMIT:  cfg_r.long_limit  <= cfg_ch.wdata[DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/bapc_front.sv -----
// Front end: accepts input beats and classifies them into operations.
module bapc_front (
  bapc_in_if.sink              in_ch,
  input  bapc_pkg::cfg_t       cfg,
  output logic                 push_valid,
  input  logic                 push_ready,
  output bapc_pkg::op_item_t   push_item
);
  import bapc_pkg::*;

  logic [HANDLER_W-1:0] handler;

  // Route the physical button through the map.
  assign handler = cfg.button_map[HANDLER_W*in_ch.button_index +: HANDLER_W];

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

  // Classify the beat.
  always_comb begin
    push_item.pressed = in_ch.pressed;
    push_item.offset  = in_ch.rotate_offset;
    push_item.op      = OP_NONE;
    case (action_t'(in_ch.action))
      ACT_TICK:   push_item.op = OP_TICK;
      ACT_ROTATE: push_item.op = OP_ROTATE;
      ACT_EDGE: begin
        case (handler_t'(handler))
          HND_CONFIRM: push_item.op = OP_CONFIRM;
          HND_BACK:    push_item.op = OP_BACK;
          HND_UP:      push_item.op = OP_UP;
          HND_DOWN:    push_item.op = OP_DOWN;
          HND_BLINK_L: push_item.op = OP_BLINK_L;
          HND_BLINK_R: push_item.op = OP_BLINK_R;
          default:     push_item.op = OP_NONE;
        endcase
      end
      default: push_item.op = OP_NONE;
    endcase
  end

endmodule

// ----- rtl/core/bapc_queue.sv -----
// Two-entry queue of classified operations between front and back end.
module bapc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  bapc_pkg::op_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output bapc_pkg::op_item_t pop_item
);
  import bapc_pkg::*;

  op_item_t   mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;
  logic       pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Occupancy update.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/core/bapc_back.sv -----
// Back end: key state, repeat timing, press classification and the result register.
module bapc_back #(
  parameter int TIMER_WIDTH = bapc_pkg::TIMER_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bapc_pkg::cfg_t     cfg,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  bapc_pkg::op_item_t pop_item,
  bapc_out_if.source         out_ch
);
  import bapc_pkg::*;

  // Compare width covering both the counters and the 16-bit limits.
  localparam int CW = (TIMER_WIDTH > DELAY_W) ? TIMER_WIDTH : DELAY_W;

  typedef struct packed {
    logic [TIMER_WIDTH-1:0] elapsed;
    logic [1:0]             repeats;
    logic                   fire;
  } key_upd_t;

  logic [ROT_W-1:0]       rot_r, rot_nxt;
  logic                   up_held_r, up_held_nxt;
  logic [TIMER_WIDTH-1:0] up_elapsed_r, up_elapsed_nxt;
  logic [1:0]             up_repeats_r, up_repeats_nxt;
  logic                   down_held_r, down_held_nxt;
  logic [TIMER_WIDTH-1:0] down_elapsed_r, down_elapsed_nxt;
  logic [1:0]             down_repeats_r, down_repeats_nxt;
  logic [TIMER_WIDTH-1:0] confirm_timer_r, confirm_timer_nxt;
  logic [TIMER_WIDTH-1:0] back_timer_r, back_timer_nxt;
  blink_t                 blink_r, blink_nxt;
  confirm_ev_t            confirm_ev;
  back_ev_t               back_ev;
  key_upd_t               up_upd;
  key_upd_t               down_upd;
  logic [ROT_W-1:0]       tick_step;
  logic                   fire;

  logic                   out_valid_r;
  logic [ROT_W-1:0]       out_rot_r;
  confirm_ev_t            out_confirm_r;
  back_ev_t               out_back_r;
  blink_t                 out_blink_r;

  // Saturating increment of a counter.
  function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] v);
    logic [TIMER_WIDTH-1:0] r;
    r = (v == '1) ? v : v + 1'b1;
    return r;
  endfunction

  // One tick of a held key: count, compare against the active delay, repeat.
  function automatic key_upd_t key_tick(input logic                   held,
                                        input logic [TIMER_WIDTH-1:0] elapsed,
                                        input logic [1:0]             repeats,
                                        input logic [DELAY_W-1:0]     slow,
                                        input logic [DELAY_W-1:0]     fast);
    key_upd_t               u;
    logic [TIMER_WIDTH-1:0] inc;
    logic [DELAY_W-1:0]     limit;
    u.elapsed = elapsed;
    u.repeats = repeats;
    u.fire    = 1'b0;
    inc       = sat_inc(elapsed);
    limit     = (repeats == REPEATS_FAST) ? fast : slow;
    if (held) begin
      u.elapsed = inc;
      if (CW'(inc) > CW'(limit)) begin
        u.elapsed = '0;
        u.fire    = 1'b1;
        if (repeats != REPEATS_FAST) begin
          u.repeats = repeats + 2'd1;
        end
      end
    end
    return u;
  endfunction

  // The back end executes when the result register is free or being drained.
  assign pop_ready = !out_valid_r || out_ch.ready;
  assign fire      = pop_valid && pop_ready;

  assign up_upd   = key_tick(up_held_r, up_elapsed_r, up_repeats_r,
                             cfg.slow_delay, cfg.fast_delay);
  assign down_upd = key_tick(down_held_r, down_elapsed_r, down_repeats_r,
                             cfg.slow_delay, cfg.fast_delay);

  // Net rotation step of one tick: up steps down, down steps up.
  always_comb begin
    tick_step = '0;
    if (up_upd.fire && !down_upd.fire) begin
      tick_step = '1;
    end else if (down_upd.fire && !up_upd.fire) begin
      tick_step = ROT_W'(1);
    end
  end

  // Next state and events of the operation at the queue head.
  always_comb begin
    rot_nxt           = rot_r;
    up_held_nxt       = up_held_r;
    up_elapsed_nxt    = up_elapsed_r;
    up_repeats_nxt    = up_repeats_r;
    down_held_nxt     = down_held_r;
    down_elapsed_nxt  = down_elapsed_r;
    down_repeats_nxt  = down_repeats_r;
    confirm_timer_nxt = confirm_timer_r;
    back_timer_nxt    = back_timer_r;
    blink_nxt         = blink_r;
    confirm_ev        = CEV_NONE;
    back_ev           = BEV_NONE;
    case (pop_item.op)
      OP_TICK: begin
        up_elapsed_nxt    = up_upd.elapsed;
        up_repeats_nxt    = up_upd.repeats;
        down_elapsed_nxt  = down_upd.elapsed;
        down_repeats_nxt  = down_upd.repeats;
        rot_nxt           = rot_r + tick_step;
        confirm_timer_nxt = sat_inc(confirm_timer_r);
        back_timer_nxt    = sat_inc(back_timer_r);
      end
      OP_ROTATE: begin
        rot_nxt = rot_r + {{(ROT_W-OFFSET_W){pop_item.offset[OFFSET_W-1]}}, pop_item.offset};
      end
      OP_CONFIRM: begin
        if (pop_item.pressed) begin
          confirm_timer_nxt = '0;
        end else begin
          if (CW'(confirm_timer_r) < CW'(cfg.short_limit)) begin
            confirm_ev = CEV_SHORT;
          end else if (CW'(confirm_timer_r) < CW'(cfg.long_limit)) begin
            confirm_ev = CEV_LONG;
          end else begin
            confirm_ev = CEV_VLONG;
          end
          confirm_timer_nxt = '1;
        end
      end
      OP_BACK: begin
        if (pop_item.pressed) begin
          back_timer_nxt = '0;
        end else begin
          back_ev        = (CW'(back_timer_r) < CW'(cfg.short_limit)) ? BEV_SHORT : BEV_LONG;
          back_timer_nxt = '1;
        end
      end
      OP_UP: begin
        up_held_nxt = pop_item.pressed;
        if (pop_item.pressed) begin
          up_elapsed_nxt = '0;
          up_repeats_nxt = 2'd0;
          rot_nxt        = rot_r - ROT_W'(1);
        end
      end
      OP_DOWN: begin
        down_held_nxt = pop_item.pressed;
        if (pop_item.pressed) begin
          down_elapsed_nxt = '0;
          down_repeats_nxt = 2'd0;
          rot_nxt          = rot_r + ROT_W'(1);
        end
      end
      OP_BLINK_L: begin
        if (pop_item.pressed) begin
          case (blink_r)
            BLINK_OFF:  blink_nxt = BLINK_RIGHT;
            BLINK_LEFT: blink_nxt = BLINK_BOTH;
            default:    blink_nxt = BLINK_OFF;
          endcase
        end
      end
      OP_BLINK_R: begin
        if (pop_item.pressed) begin
          case (blink_r)
            BLINK_OFF:   blink_nxt = BLINK_LEFT;
            BLINK_RIGHT: blink_nxt = BLINK_BOTH;
            default:     blink_nxt = BLINK_OFF;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Key and indicator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r           <= '0;
      up_held_r       <= 1'b0;
      up_elapsed_r    <= '0;
      up_repeats_r    <= 2'd0;
      down_held_r     <= 1'b0;
      down_elapsed_r  <= '0;
      down_repeats_r  <= 2'd0;
      confirm_timer_r <= '1;
      back_timer_r    <= '1;
      blink_r         <= BLINK_OFF;
    end else if (fire) begin
      rot_r           <= rot_nxt;
      up_held_r       <= up_held_nxt;
      up_elapsed_r    <= up_elapsed_nxt;
      up_repeats_r    <= up_repeats_nxt;
      down_held_r     <= down_held_nxt;
      down_elapsed_r  <= down_elapsed_nxt;
      down_repeats_r  <= down_repeats_nxt;
      confirm_timer_r <= confirm_timer_nxt;
      back_timer_r    <= back_timer_nxt;
      blink_r         <= blink_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_ready) begin
      out_valid_r <= pop_valid;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_rot_r     <= rot_nxt;
      out_confirm_r <= confirm_ev;
      out_back_r    <= back_ev;
      out_blink_r   <= blink_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.rotation_count = out_rot_r;
  assign out_ch.confirm_event  = out_confirm_r;
  assign out_ch.back_event     = out_back_r;
  assign out_ch.blink_mode     = out_blink_r;

endmodule

// ----- rtl/core/button_autorepeat_press_classifier_unit.sv -----
// Top level of the front-panel button classifier.
//
//   Channel   Dir  Beat contents
//   in_ch     in   action, button_index, pressed, rotate_offset
//   out_ch    out  rotation_count, confirm_event, back_event, blink_mode
//   cfg_ch    in   reg_index, wdata (register write, always ready)
//
// One result per input beat; a beat enters the two-entry queue in the cycle it is
// accepted; its result is registered at the queue head once the result register is
// free or being drained, so the sustained rate is one beat per clock while the
// receiver takes every result. The execute step of the back end (counter increment,
// delay compare and rotation add) sets the clock-to-clock path. Reset is synchronous
// and active low and needs no clearing pass. A stalled result holds the back end;
// the front end keeps accepting until the queue is full.
module button_autorepeat_press_classifier_unit #(
  parameter int TIMER_WIDTH = bapc_pkg::TIMER_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  bapc_in_if.sink     in_ch,
  bapc_out_if.source  out_ch,
  bapc_cfg_if.sink    cfg_ch
);
  import bapc_pkg::*;

  cfg_t     cfg;
  logic     push_valid;
  logic     push_ready;
  op_item_t push_item;
  logic     pop_valid;
  logic     pop_ready;
  op_item_t pop_item;

  // Configuration registers.
  bapc_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Classification of input beats.
  bapc_front u_front (
    .in_ch      (in_ch),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Decoupling queue.
  bapc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Execution and result register.
  bapc_back #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_ch    (out_ch)
  );

endmodule

// ----- sim/testbench.sv -----
// Testbench of the button classifier: directed table, random press sequences, predicted results.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bapc_pkg::*;

  localparam int TIMER_W = TIMER_WIDTH_DEF;
  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
  localparam int QUIET_LIMIT = 1000;
  localparam int DIR_N = 26;
  localparam int KEY_UP = 0;
  localparam int KEY_DOWN = 1;
  localparam logic [15:0] KEY_STEP [2] = '{16'hFFFF, 16'h0001};
  // Action code outside the defined set; the block must leave its state alone.
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam reg_idx_t REG_ORDER [5] = '{REG_BUTTON_MAP, REG_SLOW_DELAY, REG_FAST_DELAY,
                                         REG_SHORT_LIMIT, REG_LONG_LIMIT};

  typedef struct packed {
    logic [1:0]        action;
    logic [2:0]        btn;
    logic              pressed;
    logic signed [7:0] offset;
  } panel_beat_t;

  typedef struct packed {
    logic signed [15:0] rot;
    logic [1:0]         confirm;
    logic [1:0]         back;
    logic [1:0]         blink;
  } panel_readout_t;

  typedef struct packed {
    panel_beat_t    beat;
    logic           has_want;
    panel_readout_t want;
  } dir_row_t;

  typedef enum logic [1:0] {SINK_FREE, SINK_RANDOM, SINK_PERIODIC} sink_mode_t;

  // Opening table, default registers and the identity button map.
  localparam dir_row_t DIRECTED_ROWS [DIR_N] = '{
    '{'{ACT_TICK,   3'd0, 1'b0, 8'sd0},   1'b1, '{16'sd0,  CEV_NONE,  BEV_NONE,  BLINK_OFF}},
    '{'{ACT_EDGE,   3'd0, 1'b0, 8'sd0},   1'b1, '{16'sd0,  CEV_VLONG, BEV_NONE,  BLINK_OFF}},
    '{'{ACT_EDGE,   3'd1, 1'b0, 8'sd0},   1'b1, '{16'sd0,  CEV_NONE,  BEV_LONG,  BLINK_OFF}},
    '{'{ACT_ROTATE, 3'd0, 1'b0, 8'sd127}, 1'b1, '{16'sd127, CEV_NONE, BEV_NONE,  BLINK_OFF}},
    '{'{ACT_ROTATE, 3'd7, 1'b1, 8'sh80},  1'b1, '{-16'sd1, CEV_NONE,  BEV_NONE,  BLINK_OFF}},
    '{'{ACT_EDGE,   3'd2, 1'b1, 8'sd0},   1'b1, '{-16'sd2, CEV_NONE,  BEV_NONE,  BLINK_OFF}},
    '{'{ACT_EDGE,   3'd2, 1'b1, 8'sd0},   1'b1, '{-16'sd3, CEV_NONE,  BEV_NONE,  BLINK_OFF}},
    '{'{ACT_EDGE,   3'd2, 1'b0, 8'sd0},   1'b1, '{-16'sd3, CEV_NONE,  BEV_NONE,  BLINK_OFF}},
    '{'{ACT_EDGE,   3'd3, 1'b1, 8'sd0},   1'b1, '{-16'sd2, CEV_NONE,  BEV_NONE,  BLINK_OFF}},
    '{'{ACT_TICK,   3'd0, 1'b0, 8'sd0},   1'b0, '0},
    '{'{ACT_EDGE,   3'd3, 1'b0, 8'sd0},   1'b0, '0},
    '{'{ACT_EDGE,   3'd4, 1'b1, 8'sd0},   1'b1, '{-16'sd2, CEV_NONE,  BEV_NONE,  BLINK_RIGHT}},
    '{'{ACT_EDGE,   3'd5, 1'b1, 8'sd0},   1'b1, '{-16'sd2, CEV_NONE,  BEV_NONE,  BLINK_BOTH}},
    '{'{ACT_EDGE,   3'd4, 1'b1, 8'sd0},   1'b1, '{-16'sd2, CEV_NONE,  BEV_NONE,  BLINK_OFF}},
    '{'{ACT_EDGE,   3'd5, 1'b1, 8'sd0},   1'b1, '{-16'sd2, CEV_NONE,  BEV_NONE,  BLINK_LEFT}},
    '{'{ACT_EDGE,   3'd4, 1'b1, 8'sd0},   1'b1, '{-16'sd2, CEV_NONE,  BEV_NONE,  BLINK_BOTH}},
    '{'{ACT_EDGE,   3'd5, 1'b1, 8'sd0},   1'b1, '{-16'sd2, CEV_NONE,  BEV_NONE,  BLINK_OFF}},
    '{'{ACT_EDGE,   3'd6, 1'b1, 8'sd0},   1'b0, '0},
    '{'{ACT_EDGE,   3'd7, 1'b0, 8'sd0},   1'b0, '0},
    '{'{ACT_SPARE,  3'd5, 1'b1, 8'sh55},  1'b0, '0},
    '{'{ACT_EDGE,   3'd0, 1'b1, 8'sd0},   1'b0, '0},
    '{'{ACT_TICK,   3'd0, 1'b0, 8'sd0},   1'b0, '0},
    '{'{ACT_EDGE,   3'd0, 1'b0, 8'sd0},   1'b1, '{-16'sd2, CEV_SHORT, BEV_NONE,  BLINK_OFF}},
    '{'{ACT_EDGE,   3'd1, 1'b1, 8'sd0},   1'b0, '0},
    '{'{ACT_TICK,   3'd7, 1'b1, -8'sd1},  1'b0, '0},
    '{'{ACT_EDGE,   3'd1, 1'b0, 8'sd0},   1'b1, '{-16'sd2, CEV_NONE,  BEV_SHORT, BLINK_OFF}}
  };

  logic clk = 1'b0;
  logic rst_n;

  bapc_in_if  in_if ();
  bapc_out_if out_if ();
  bapc_cfg_if cfg_if ();

  button_autorepeat_press_classifier_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register copies and panel state as the block should hold them.
  logic [MAP_W-1:0]   cur_map   = BUTTON_MAP_RST;
  logic [DELAY_W-1:0] cur_slow  = SLOW_DELAY_RST;
  logic [DELAY_W-1:0] cur_fast  = FAST_DELAY_RST;
  logic [DELAY_W-1:0] cur_short = SHORT_LIMIT_RST;
  logic [DELAY_W-1:0] cur_long  = LONG_LIMIT_RST;

  logic [15:0]        rot_acc     = '0;
  logic               key_held [2] = '{1'b0, 1'b0};
  logic [TIMER_W-1:0] key_time [2] = '{'0, '0};
  logic [1:0]         key_reps [2] = '{2'd0, 2'd0};
  logic [TIMER_W-1:0] confirm_age = TIMER_MAX;
  logic [TIMER_W-1:0] back_age    = TIMER_MAX;
  logic [1:0]         blink_now   = BLINK_OFF;

  panel_readout_t awaited_readouts [$];
  int mismatches = 0;
  int beats_sent = 0;
  int burst_left = 0;
  int hold_cap   = 300;
  int quiet_cycles = 0;

  // Advance the panel state by one input beat and return the readout it yields.
  function automatic panel_readout_t panel_update(panel_beat_t b);
    panel_readout_t r;
    logic [2:0] hnd;
    logic [TIMER_W-1:0] lim;
    int k;
    r = '0;
    case (b.action)
      ACT_TICK: begin
        // Up is handled before down, so a shared tick steps up first.
        for (int i = 0; i < 2; i++) begin
          if (key_held[i]) begin
            if (key_time[i] != TIMER_MAX) key_time[i]++;
            lim = (key_reps[i] == REPEATS_FAST) ? TIMER_W'(cur_fast) : TIMER_W'(cur_slow);
            if (key_time[i] > lim) begin
              key_time[i] = '0;
              if (key_reps[i] != REPEATS_FAST) key_reps[i]++;
              rot_acc = rot_acc + KEY_STEP[i];
            end
          end
        end
        if (confirm_age != TIMER_MAX) confirm_age++;
        if (back_age != TIMER_MAX) back_age++;
      end
      ACT_EDGE: begin
        hnd = cur_map[3*b.btn +: 3];
        case (hnd)
          HND_CONFIRM: begin
            if (b.pressed) begin
              confirm_age = '0;
            end else begin
              if (confirm_age < cur_short) r.confirm = CEV_SHORT;
              else if (confirm_age < cur_long) r.confirm = CEV_LONG;
              else r.confirm = CEV_VLONG;
              confirm_age = TIMER_MAX;
            end
          end
          HND_BACK: begin
            if (b.pressed) begin
              back_age = '0;
            end else begin
              r.back = (back_age < cur_short) ? BEV_SHORT : BEV_LONG;
              back_age = TIMER_MAX;
            end
          end
          HND_UP, HND_DOWN: begin
            k = (hnd == HND_UP) ? KEY_UP : KEY_DOWN;
            key_held[k] = b.pressed;
            if (b.pressed) begin
              key_time[k] = '0;
              key_reps[k] = 2'd0;
              rot_acc = rot_acc + KEY_STEP[k];
            end
          end
          // The left key lights the right-hand code from off, as the panel expects.
          HND_BLINK_L: begin
            if (b.pressed)
              blink_now = (blink_now == BLINK_OFF) ? BLINK_RIGHT :
                          (blink_now == BLINK_LEFT) ? BLINK_BOTH : BLINK_OFF;
          end
          HND_BLINK_R: begin
            if (b.pressed)
              blink_now = (blink_now == BLINK_OFF) ? BLINK_LEFT :
                          (blink_now == BLINK_RIGHT) ? BLINK_BOTH : BLINK_OFF;
          end
          default: ;
        endcase
      end
      ACT_ROTATE: rot_acc = rot_acc + {{8{b.offset[7]}}, b.offset};
      default: ;
    endcase
    r.rot = rot_acc;
    r.blink = blink_now;
    return r;
  endfunction

  function automatic panel_beat_t random_beat_of(logic [1:0] act);
    panel_beat_t b;
    logic [31:0] bits;
    bits = $urandom();
    b.action = act;
    b.btn = bits[2:0];
    b.pressed = bits[3];
    b.offset = bits[15:8];
    return b;
  endfunction

  function automatic panel_beat_t random_beat();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return random_beat_of(ACT_TICK);
    if (pick < 70) return random_beat_of(ACT_EDGE);
    if (pick < 96) return random_beat_of(ACT_ROTATE);
    return random_beat_of(ACT_SPARE);
  endfunction

  // Present one beat in the sender's burst pattern and record its expected readout.
  task automatic send_beat(panel_beat_t b, logic has_want, panel_readout_t want);
    int gap;
    panel_readout_t predicted;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(150, 400);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 5);
      end
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.action <= b.action;
    in_if.button_index <= b.btn;
    in_if.pressed <= b.pressed;
    in_if.rotate_offset <= b.offset;
    do @(posedge clk); while (!in_if.ready);
    predicted = panel_update(b);
    awaited_readouts.push_back(has_want ? want : predicted);
    beats_sent++;
    @(negedge clk);
  endtask

  // Let the block drain, then rewrite all five registers back to back.
  task automatic set_config(logic [MAP_W-1:0] map, logic [15:0] slow, logic [15:0] fast,
                            logic [15:0] short_lim, logic [15:0] long_lim);
    logic [CFG_DATA_W-1:0] vals [5];
    in_if.valid <= 1'b0;
    while (awaited_readouts.size() != 0) @(negedge clk);
    // Delay registers get junk above bit 15; only the low 16 bits may take effect.
    vals[0] = map;
    vals[1] = {8'($urandom()), slow};
    vals[2] = {8'($urandom()), fast};
    vals[3] = {8'($urandom()), short_lim};
    vals[4] = {8'($urandom()), long_lim};
    for (int i = 0; i < 5; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.reg_index <= REG_ORDER[i];
      cfg_if.wdata <= vals[i];
      do @(posedge clk); while (!cfg_if.ready);
      case (REG_ORDER[i])
        REG_BUTTON_MAP:  cur_map = vals[i][MAP_W-1:0];
        REG_SLOW_DELAY:  cur_slow = vals[i][DELAY_W-1:0];
        REG_FAST_DELAY:  cur_fast = vals[i][DELAY_W-1:0];
        REG_SHORT_LIMIT: cur_short = vals[i][DELAY_W-1:0];
        REG_LONG_LIMIT:  cur_long = vals[i][DELAY_W-1:0];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Press a button, hold it for a number of ticks around the thresholds, and mostly release it.
  // The hold is kept within the beats left in the current phase.
  task automatic press_and_hold(int budget);
    panel_beat_t b;
    int btn;
    int hold;
    int span;
    btn = $urandom_range(0, 7);
    for (int t = 0; t < 3 && cur_map[3*btn +: 3] > HND_BLINK_R; t++)
      btn = $urandom_range(0, 7);
    b = random_beat_of(ACT_EDGE);
    b.btn = btn[2:0];
    b.pressed = 1'b1;
    send_beat(b, 1'b0, '0);
    span = 3 * int'(cur_slow) + 2 * int'(cur_fast);
    if (int'(cur_long) > span) span = int'(cur_long);
    span = span + 4;
    if (span > hold_cap) span = hold_cap;
    case ($urandom_range(0, 3))
      0: hold = int'(cur_short) - 1 + int'($urandom_range(0, 1));
      1: hold = int'(cur_long) - 1 + int'($urandom_range(0, 1));
      default: hold = $urandom_range(0, span);
    endcase
    if (hold > hold_cap) hold = hold_cap;
    if (hold > budget - 2) hold = budget - 2;
    if (hold < 0) hold = 0;
    repeat (hold) begin
      if ($urandom_range(0, 99) < 12) send_beat(random_beat(), 1'b0, '0);
      send_beat(random_beat_of(ACT_TICK), 1'b0, '0);
    end
    // Now and then the key is left held into whatever comes next.
    if ($urandom_range(0, 9) != 0) begin
      b = random_beat_of(ACT_EDGE);
      b.btn = btn[2:0];
      b.pressed = 1'b0;
      send_beat(b, 1'b0, '0);
    end
  endtask

  task automatic drive_random(int n);
    int start;
    start = beats_sent;
    while (beats_sent - start < n) begin
      if ($urandom_range(0, 99) < 70) press_and_hold(n - (beats_sent - start));
      else send_beat(random_beat(), 1'b0, '0);
    end
  endtask

  task automatic note_mismatch(string what, panel_readout_t want, panel_readout_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%s: expected rot=%0d confirm=%0d back=%0d blink=%0d,",
                " got rot=%0d confirm=%0d back=%0d blink=%0d"},
               what, want.rot, want.confirm, want.back, want.blink,
               got.rot, got.confirm, got.back, got.blink);
  endtask

  // Result monitor: each accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    panel_readout_t got;
    panel_readout_t want;
    if (rst_n === 1'b1 && out_if.valid && out_if.ready) begin
      got = '{out_if.rotation_count, out_if.confirm_event, out_if.back_event,
              out_if.blink_mode};
      if (awaited_readouts.size() == 0) begin
        note_mismatch("result beat with nothing pending", '0, got);
      end else begin
        want = awaited_readouts.pop_front();
        if (got !== want) note_mismatch("result mismatch", want, got);
      end
    end
  end

  // Watchdog on cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: switches between always ready, random stalls and a fixed duty pattern.
  initial begin
    sink_mode_t mode;
    int mode_left;
    int stall_run;
    int phase_cnt;
    logic take;
    out_if.ready = 1'b0;
    mode = SINK_FREE;
    mode_left = 0;
    stall_run = 0;
    phase_cnt = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      phase_cnt++;
      case (mode)
        SINK_FREE:   take = 1'b1;
        SINK_RANDOM: take = ($urandom_range(0, 2) != 0);
        default:     take = (phase_cnt % 5) < 3;
      endcase
      stall_run = take ? 0 : stall_run + 1;
      if (stall_run > 6) begin
        take = 1'b1;
        stall_run = 0;
      end
      out_if.ready <= take;
    end
  end

  // Main sequence: reset, directed table, then phases of random traffic.
  initial begin
    panel_beat_t b;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = ACT_TICK;
    in_if.button_index = '0;
    in_if.pressed = 1'b0;
    in_if.rotate_offset = '0;
    cfg_if.valid = 1'b0;
    cfg_if.reg_index = REG_BUTTON_MAP;
    cfg_if.wdata = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++)
      send_beat(DIRECTED_ROWS[i].beat, DIRECTED_ROWS[i].has_want, DIRECTED_ROWS[i].want);

    // Short delays so that repeats, fast repeats and every class show up often.
    set_config(BUTTON_MAP_RST, 16'd3, 16'd1, 16'd6, 16'd15);
    drive_random(150);

    // Random button map, buttons may share a handler.
    set_config(24'($urandom()), 16'($urandom_range(1, 6)), 16'($urandom_range(1, 3)),
               16'($urandom_range(1, 20)), 16'($urandom_range(1, 40)));
    drive_random(150);

    // Low extremes: every button routed to confirm, all thresholds at one.
    set_config(24'h000000, 16'd1, 16'd1, 16'd1, 16'd1);
    drive_random(100);

    // Zero thresholds: a held key repeats on every tick and no release is short.
    set_config(BUTTON_MAP_RST, 16'd0, 16'd0, 16'd0, 16'd0);
    drive_random(100);

    // High extremes: every edge has no effect.
    set_config(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drive_random(40);

    // Highest thresholds: hold all four timed keys for a while; nothing repeats.
    set_config(BUTTON_MAP_RST, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int k = 0; k < 4; k++) begin
      b = random_beat_of(ACT_EDGE);
      b.btn = 3'(k);
      b.pressed = 1'b1;
      send_beat(b, 1'b0, '0);
    end
    repeat (30) send_beat(random_beat_of(ACT_TICK), 1'b0, '0);
    for (int k = 0; k < 4; k++) begin
      b = random_beat_of(ACT_EDGE);
      b.btn = 3'(k);
      b.pressed = 1'b0;
      send_beat(b, 1'b0, '0);
    end
    drive_random(60);

    set_config(BUTTON_MAP_RST, 16'($urandom_range(1, 12)), 16'($urandom_range(1, 4)),
               16'($urandom_range(1, 30)), 16'($urandom_range(1, 60)));
    drive_random(150);

    set_config(24'($urandom()), 16'($urandom_range(1, 60)), 16'($urandom_range(1, 20)),
               16'($urandom_range(1, 120)), 16'($urandom_range(1, 250)));
    drive_random(150);

    // Reset values again; holds stay short of the default thresholds.
    set_config(BUTTON_MAP_RST, SLOW_DELAY_RST, FAST_DELAY_RST, SHORT_LIMIT_RST,
               LONG_LIMIT_RST);
    drive_random(100);

    in_if.valid <= 1'b0;
    while (awaited_readouts.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && awaited_readouts.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/bapc_pkg.sv
rtl/core/bapc_channels.sv
rtl/core/bapc_cfg_regs.sv
rtl/core/bapc_front.sv
rtl/core/bapc_queue.sv
rtl/core/bapc_back.sv
rtl/core/button_autorepeat_press_classifier_unit.sv
sim/testbench.sv
